[src/accs_pkg.sv]
// ----------------------------------------------------------------------------
// accs_pkg
// shared types and constants of the step counter
// ----------------------------------------------------------------------------
package accs_pkg;

    localparam int unsigned ADDR_W = 5;

    localparam logic [2:0] REG_RISE_THRESHOLD  = 3'd0;
    localparam logic [2:0] REG_MIN_GAP         = 3'd1;
    localparam logic [2:0] REG_BONUS_FLOOR     = 3'd2;
    localparam logic [2:0] REG_STEPS_PER_KCAL  = 3'd3;
    localparam logic [2:0] REG_POINTS_PER_KCAL = 3'd4;
    localparam logic [2:0] REG_GOAL_STEP       = 3'd5;
    localparam logic [2:0] REG_GOAL_LIMIT      = 3'd6;

    localparam logic [15:0] RST_RISE_THRESHOLD  = 16'd600;
    localparam logic [15:0] RST_MIN_GAP         = 16'd1;
    localparam logic [15:0] RST_BONUS_FLOOR     = 16'd350;
    localparam logic [7:0]  RST_STEPS_PER_KCAL  = 8'd25;
    localparam logic [15:0] RST_POINTS_PER_KCAL = 16'd5000;
    localparam logic [7:0]  RST_GOAL_STEP       = 8'd5;
    localparam logic [15:0] RST_GOAL_LIMIT      = 16'd50000;
    localparam logic [15:0] RST_STEP_GOAL       = 16'd15;

    localparam logic [15:0] GAP_SAT   = 16'd60000;
    localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;
    localparam logic [15:0] RECIP_10  = 16'hCCCD;
    localparam int unsigned RECIP_SH  = 19;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_POLL   = 1'b1;

    typedef struct packed {
        logic [15:0] rise_threshold;
        logic [15:0] min_gap;
        logic [15:0] bonus_floor;
        logic [7:0]  steps_per_kcal;
        logic [15:0] points_per_kcal;
        logic [7:0]  goal_step;
        logic [15:0] goal_limit;
    } cfg_t;

    typedef struct packed {
        logic               opcode;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [15:0]        goal;
    } entry_t;

endpackage

[src/accel_step_counter.sv]
// ----------------------------------------------------------------------------
// accel_step_counter
// pedometer over 3-axis accelerometer samples with apb configuration
// ----------------------------------------------------------------------------
// A sample beat, once it leaves the input queue, takes three squares on one
// 16x16 multiplier, 16 square root steps at two bits each, an update and a
// bonus step, then two 32-step restoring divisions for the calorie total on
// one shared divider, and the result register load. A button poll beat
// skips the magnitude work and the update. A two-beat queue in front lets
// inputs be taken while the back end works and while a result waits to be
// taken.
// ----------------------------------------------------------------------------
module accel_step_counter
    import accs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic               button_a_down,
    input  logic               button_b_down,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               step_detected,
    output logic [23:0]        step_total,
    output logic [23:0]        kcal_total,
    output logic [15:0]        goal_value,
    output logic               goal_reached,
    output logic signed [16:0] magnitude_change,
    output logic [15:0]        smoothed_intensity
);

    cfg_t   cfg;
    logic   push, pop, q_full, q_empty;
    entry_t push_entry, pop_entry;

    accs_regs u_regs (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    accs_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .accel_x(accel_x), .accel_y(accel_y), .accel_z(accel_z),
        .button_a_down(button_a_down), .button_b_down(button_b_down),
        .q_full(q_full), .push(push), .push_entry(push_entry)
    );

    accs_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_entry(push_entry),
        .pop(pop), .pop_entry(pop_entry), .full(q_full), .empty(q_empty)
    );

    accs_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .q_empty(q_empty), .q_entry(pop_entry),
        .pop(pop), .out_valid(out_valid), .out_ready(out_ready),
        .step_detected(step_detected), .step_total(step_total),
        .kcal_total(kcal_total), .goal_value(goal_value), .goal_reached(goal_reached),
        .magnitude_change(magnitude_change), .smoothed_intensity(smoothed_intensity)
    );

endmodule

[src/accs_regs.sv]
// ----------------------------------------------------------------------------
// accs_regs
// configuration registers behind the apb port
// ----------------------------------------------------------------------------
module accs_regs
    import accs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[ADDR_W-1:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rise_threshold  <= RST_RISE_THRESHOLD;
            cfg_reg.min_gap         <= RST_MIN_GAP;
            cfg_reg.bonus_floor     <= RST_BONUS_FLOOR;
            cfg_reg.steps_per_kcal  <= RST_STEPS_PER_KCAL;
            cfg_reg.points_per_kcal <= RST_POINTS_PER_KCAL;
            cfg_reg.goal_step       <= RST_GOAL_STEP;
            cfg_reg.goal_limit      <= RST_GOAL_LIMIT;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_RISE_THRESHOLD:  cfg_reg.rise_threshold  <= pwdata[15:0];
                REG_MIN_GAP:         cfg_reg.min_gap         <= pwdata[15:0];
                REG_BONUS_FLOOR:     cfg_reg.bonus_floor     <= pwdata[15:0];
                REG_STEPS_PER_KCAL:  cfg_reg.steps_per_kcal  <= pwdata[7:0];
                REG_POINTS_PER_KCAL: cfg_reg.points_per_kcal <= pwdata[15:0];
                REG_GOAL_STEP:       cfg_reg.goal_step       <= pwdata[7:0];
                REG_GOAL_LIMIT:      cfg_reg.goal_limit      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_RISE_THRESHOLD:  prdata = {16'd0, cfg_reg.rise_threshold};
            REG_MIN_GAP:         prdata = {16'd0, cfg_reg.min_gap};
            REG_BONUS_FLOOR:     prdata = {16'd0, cfg_reg.bonus_floor};
            REG_STEPS_PER_KCAL:  prdata = {24'd0, cfg_reg.steps_per_kcal};
            REG_POINTS_PER_KCAL: prdata = {16'd0, cfg_reg.points_per_kcal};
            REG_GOAL_STEP:       prdata = {24'd0, cfg_reg.goal_step};
            REG_GOAL_LIMIT:      prdata = {16'd0, cfg_reg.goal_limit};
            default:             prdata = 32'd0;
        endcase
    end

endmodule

[src/accs_front.sv]
// ----------------------------------------------------------------------------
// accs_front
// input beat acceptance, button edge detection and step goal update
// ----------------------------------------------------------------------------
module accs_front
    import accs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic               button_a_down,
    input  logic               button_b_down,
    input  logic               q_full,
    output logic               push,
    output entry_t             push_entry
);

    logic [15:0] goal_reg, goal_next, goal_b;
    logic        last_a_reg, last_b_reg;
    logic [16:0] goal_sum;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        goal_sum = {1'b0, goal_reg} + {9'd0, cfg.goal_step};
        goal_b   = goal_reg;
        if (button_b_down && !last_b_reg)
        begin
            goal_b = (goal_sum > {1'b0, cfg.goal_limit}) ? cfg.goal_limit : goal_sum[15:0];
        end
        goal_next = goal_b;
        if (button_a_down && !last_a_reg)
        begin
            goal_next = (goal_b >= {8'd0, cfg.goal_step}) ?
                        goal_b - {8'd0, cfg.goal_step} : 16'd0;
        end
    end

    assign push_entry = '{opcode: opcode, accel_x: accel_x, accel_y: accel_y,
                          accel_z: accel_z, goal: goal_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg   <= RST_STEP_GOAL;
            last_a_reg <= 1'b0;
            last_b_reg <= 1'b0;
        end
        else if (push)
        begin
            goal_reg   <= goal_next;
            last_a_reg <= button_a_down;
            last_b_reg <= button_b_down;
        end
    end

endmodule

[src/accs_queue.sv]
// ----------------------------------------------------------------------------
// accs_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module accs_queue
    import accs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t pop_entry,
    output logic   full,
    output logic   empty
);

    entry_t     mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign full      = (cnt_reg == 2'd2);
    assign empty     = (cnt_reg == 2'd0);
    assign pop_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

[src/accs_back.sv]
// ----------------------------------------------------------------------------
// accs_back
// magnitude, smoothing, step decision, calorie divisions and result register
// ----------------------------------------------------------------------------
module accs_back
    import accs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               q_empty,
    input  entry_t             q_entry,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               step_detected,
    output logic [23:0]        step_total,
    output logic [23:0]        kcal_total,
    output logic [15:0]        goal_value,
    output logic               goal_reached,
    output logic signed [16:0] magnitude_change,
    output logic [15:0]        smoothed_intensity
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQX   = 4'd1;
    localparam logic [3:0] ST_SQY   = 4'd2;
    localparam logic [3:0] ST_SQZ   = 4'd3;
    localparam logic [3:0] ST_ROOT  = 4'd4;
    localparam logic [3:0] ST_UPD   = 4'd5;
    localparam logic [3:0] ST_BONUS = 4'd6;
    localparam logic [3:0] ST_DIVA  = 4'd7;
    localparam logic [3:0] ST_DIVB  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    logic [3:0]         state_reg;
    entry_t             item_reg;
    logic [31:0]        acc_reg;
    logic [15:0]        rem_reg;
    logic [15:0]        root_reg;
    logic [4:0]         cnt_reg;
    logic [15:0]        last_mag_reg;
    logic [15:0]        since_reg;
    logic [15:0]        avg_reg;
    logic [23:0]        steps_reg;
    logic [31:0]        bonus_reg;
    logic               stepped_reg;
    logic signed [16:0] diff_reg;
    logic               bonus_en_reg;
    logic [15:0]        bonus_delta_reg;
    logic [15:0]        div_rem_reg;
    logic [31:0]        div_q_reg;
    logic [23:0]        base_reg;
    logic               out_valid_reg;

    logic signed [15:0] sq_op;
    logic signed [31:0] sq_prod;
    logic [17:0]        root_rem;
    logic [17:0]        root_trial;
    logic signed [16:0] diff;
    logic [15:0]        abs_diff;
    logic [18:0]        avg_sum;
    logic [15:0]        avg_new;
    logic               step_hit;
    logic [31:0]        bonus_prod;
    logic [15:0]        divisor;
    logic [16:0]        div_trial;
    logic [32:0]        kcal_sum;

    assign pop       = (state_reg == ST_IDLE) && !q_empty && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        case (state_reg)
            ST_SQX:  sq_op = item_reg.accel_x;
            ST_SQY:  sq_op = item_reg.accel_y;
            default: sq_op = item_reg.accel_z;
        endcase
        sq_prod = sq_op * sq_op;
    end

    // two bits of the radicand per step
    assign root_rem   = {rem_reg, acc_reg[31:30]};
    assign root_trial = {root_reg, 2'b01};

    always_comb
    begin
        diff     = $signed({1'b0, root_reg}) - $signed({1'b0, last_mag_reg});
        abs_diff = diff[16] ? 16'(-diff) : diff[15:0];
        avg_sum  = {avg_reg, 3'b000} - {3'd0, avg_reg} + {3'd0, abs_diff};
        avg_new  = avg_sum[18:3];
        step_hit = (diff > $signed({1'b0, cfg.rise_threshold})) && (since_reg > cfg.min_gap);
    end

    assign bonus_prod = bonus_delta_reg * RECIP_10;

    always_comb
    begin
        if (state_reg == ST_DIVA)
        begin
            divisor = (cfg.steps_per_kcal == 8'd0) ? 16'd1 : {8'd0, cfg.steps_per_kcal};
        end
        else
        begin
            divisor = (cfg.points_per_kcal == 16'd0) ? 16'd1 : cfg.points_per_kcal;
        end
        div_trial = {div_rem_reg, div_q_reg[31]};
    end

    assign kcal_sum = {9'd0, base_reg} + {1'b0, div_q_reg};

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    item_reg <= q_entry;
                end
            end
            ST_SQX:
            begin
                acc_reg <= 32'(sq_prod);
            end
            ST_SQY:
            begin
                acc_reg <= acc_reg + 32'(sq_prod);
            end
            ST_SQZ:
            begin
                acc_reg  <= acc_reg + 32'(sq_prod);
                rem_reg  <= 16'd0;
                root_reg <= 16'd0;
                cnt_reg  <= 5'd0;
            end
            ST_ROOT:
            begin
                acc_reg <= {acc_reg[29:0], 2'b00};
                cnt_reg <= cnt_reg + 5'd1;
                if (root_rem >= root_trial)
                begin
                    rem_reg  <= 16'(root_rem - root_trial);
                    root_reg <= {root_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= root_rem[15:0];
                    root_reg <= {root_reg[14:0], 1'b0};
                end
            end
            ST_UPD:
            begin
                diff_reg        <= diff;
                stepped_reg     <= step_hit;
                bonus_en_reg    <= step_hit && (avg_new > cfg.bonus_floor);
                bonus_delta_reg <= avg_new - cfg.bonus_floor;
            end
            ST_BONUS:
            begin
                div_rem_reg <= 16'd0;
                div_q_reg   <= {8'd0, steps_reg};
                cnt_reg     <= 5'd0;
            end
            ST_DIVA, ST_DIVB:
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if ((state_reg == ST_DIVA) && (cnt_reg == 5'd31))
                begin
                    base_reg    <= {div_q_reg[22:0], (div_trial >= {1'b0, divisor})};
                    div_rem_reg <= 16'd0;
                    div_q_reg   <= bonus_reg;
                end
                else if (div_trial >= {1'b0, divisor})
                begin
                    div_rem_reg <= 16'(div_trial - {1'b0, divisor});
                    div_q_reg   <= {div_q_reg[30:0], 1'b1};
                end
                else
                begin
                    div_rem_reg <= div_trial[15:0];
                    div_q_reg   <= {div_q_reg[30:0], 1'b0};
                end
            end
            ST_OUT:
            begin
                step_total         <= steps_reg;
                kcal_total         <= (kcal_sum > {9'd0, COUNT_MAX}) ? COUNT_MAX :
                                      kcal_sum[23:0];
                goal_value         <= item_reg.goal;
                goal_reached       <= (steps_reg >= {8'd0, item_reg.goal});
                smoothed_intensity <= avg_reg;
                if (item_reg.opcode == OP_SAMPLE)
                begin
                    step_detected    <= stepped_reg;
                    magnitude_change <= diff_reg;
                end
                else
                begin
                    step_detected    <= 1'b0;
                    magnitude_change <= 17'sd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            last_mag_reg  <= 16'd0;
            since_reg     <= 16'd0;
            avg_reg       <= 16'd0;
            steps_reg     <= 24'd0;
            bonus_reg     <= 32'd0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (pop)
                    begin
                        state_reg <= (q_entry.opcode == OP_SAMPLE) ? ST_SQX : ST_BONUS;
                    end
                end
                ST_SQX:  state_reg <= ST_SQY;
                ST_SQY:  state_reg <= ST_SQZ;
                ST_SQZ:  state_reg <= ST_ROOT;
                ST_ROOT:
                begin
                    if (cnt_reg == 5'd15)
                    begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    last_mag_reg <= root_reg;
                    avg_reg      <= avg_new;
                    if (step_hit)
                    begin
                        since_reg <= 16'd0;
                        if (steps_reg != COUNT_MAX)
                        begin
                            steps_reg <= steps_reg + 24'd1;
                        end
                    end
                    else if (since_reg < GAP_SAT)
                    begin
                        since_reg <= since_reg + 16'd1;
                    end
                    state_reg <= ST_BONUS;
                end
                ST_BONUS:
                begin
                    if ((item_reg.opcode == OP_SAMPLE) && bonus_en_reg)
                    begin
                        bonus_reg <= bonus_reg + {19'd0, bonus_prod[RECIP_SH +: 13]};
                    end
                    state_reg <= ST_DIVA;
                end
                ST_DIVA:
                begin
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= ST_DIVB;
                    end
                end
                ST_DIVB:
                begin
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

[src/accs_checker.sv]
// ----------------------------------------------------------------------------
// accs_checker
// port-level checks of the step counter
// ----------------------------------------------------------------------------
module accs_checker
    import accs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               step_detected,
    input logic [23:0]        step_total,
    input logic [15:0]        goal_value,
    input logic               goal_reached,
    input logic signed [16:0] magnitude_change
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(step_total))
        else $error("result beat dropped while stalled");

    a_goal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (goal_reached == ({8'd0, goal_value} <= step_total)))
        else $error("goal flag disagrees with totals");

    a_step_rise: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_detected |-> !magnitude_change[16] && (magnitude_change != 17'sd0))
        else $error("step without magnitude rise");

    a_step_total: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && step_detected |-> step_total != 24'd0)
        else $error("step with zero total");

endmodule

bind accel_step_counter accs_checker u_accs_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .step_detected(step_detected), .step_total(step_total), .goal_value(goal_value),
    .goal_reached(goal_reached), .magnitude_change(magnitude_change)
);
